// File: sv/kar_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package kar_pkg;

    localparam int MASK_W     = 8;
    localparam int DELAY_W    = 16;
    localparam int COUNT_W    = 7;
    localparam int NUM_STEPS  = 6;
    localparam int STEP_IDX_W = 3;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [COUNT_W-1:0] COUNT_MAX = 7'd80;

    localparam logic [DELAY_W-1:0] INITIAL_DELAY_RST = 16'd350;
    localparam logic [DELAY_W-1:0] STEP0_RST         = 16'd100;
    localparam logic [DELAY_W-1:0] STEP1_RST         = 16'd50;
    localparam logic [DELAY_W-1:0] STEP2_RST         = 16'd50;
    localparam logic [DELAY_W-1:0] STEP3_RST         = 16'd50;
    localparam logic [DELAY_W-1:0] STEP4_RST         = 16'd50;
    localparam logic [DELAY_W-1:0] STEP5_RST         = 16'd15;
    localparam logic [MASK_W-1:0]  ENABLE_RST        = 8'd15;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_INITIAL_DELAY = 3'd0,
        REG_STEP0         = 3'd1,
        REG_STEP1         = 3'd2,
        REG_STEP2         = 3'd3,
        REG_STEP3         = 3'd4,
        REG_STEP4         = 3'd5,
        REG_STEP5         = 3'd6,
        REG_REPEAT_ENABLE = 3'd7
    } cfg_idx_t;

    typedef struct packed {
        logic [DELAY_W-1:0]                initial_delay;
        logic [NUM_STEPS-1:0][DELAY_W-1:0] delay_step;
        logic [MASK_W-1:0]                 repeat_enable;
    } cfg_t;

endpackage

`default_nettype wire

// File: sv/kar_cfg.sv
`timescale 1ns / 1ps
`default_nettype none

module kar_cfg
(
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           wr_en,
    input  wire logic [kar_pkg::CFG_IDX_W-1:0]  wr_index,
    input  wire logic [kar_pkg::CFG_DATA_W-1:0] wr_data,
    output kar_pkg::cfg_t                       cfg
);

    kar_pkg::cfg_t cfg_reg;
    kar_pkg::cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (kar_pkg::cfg_idx_t'(wr_index))
                kar_pkg::REG_INITIAL_DELAY: cfg_next.initial_delay = wr_data;
                kar_pkg::REG_STEP0:         cfg_next.delay_step[0] = wr_data;
                kar_pkg::REG_STEP1:         cfg_next.delay_step[1] = wr_data;
                kar_pkg::REG_STEP2:         cfg_next.delay_step[2] = wr_data;
                kar_pkg::REG_STEP3:         cfg_next.delay_step[3] = wr_data;
                kar_pkg::REG_STEP4:         cfg_next.delay_step[4] = wr_data;
                kar_pkg::REG_STEP5:         cfg_next.delay_step[5] = wr_data;
                kar_pkg::REG_REPEAT_ENABLE:
                    cfg_next.repeat_enable = wr_data[kar_pkg::MASK_W-1:0];
                default:                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.initial_delay <= kar_pkg::INITIAL_DELAY_RST;
            cfg_reg.delay_step[0] <= kar_pkg::STEP0_RST;
            cfg_reg.delay_step[1] <= kar_pkg::STEP1_RST;
            cfg_reg.delay_step[2] <= kar_pkg::STEP2_RST;
            cfg_reg.delay_step[3] <= kar_pkg::STEP3_RST;
            cfg_reg.delay_step[4] <= kar_pkg::STEP4_RST;
            cfg_reg.delay_step[5] <= kar_pkg::STEP5_RST;
            cfg_reg.repeat_enable <= kar_pkg::ENABLE_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

// File: sv/kar_lane.sv
`timescale 1ns / 1ps
`default_nettype none

module kar_lane
(
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        update,
    input  wire logic                        down,
    input  wire logic                        held,
    input  wire logic                        enable,
    input  wire logic [kar_pkg::DELAY_W-1:0] elapsed,
    input  wire kar_pkg::cfg_t               cfg,
    output logic                             press,
    output logic                             fire
);

    logic [kar_pkg::DELAY_W-1:0]    timer_reg;
    logic [kar_pkg::DELAY_W-1:0]    timer_next;
    logic [kar_pkg::COUNT_W-1:0]    count_reg;
    logic [kar_pkg::COUNT_W-1:0]    count_next;
    logic [kar_pkg::COUNT_W-1:0]    count_inc;
    logic [kar_pkg::STEP_IDX_W-1:0] step_idx;
    logic [kar_pkg::DELAY_W-1:0]    step_delay;
    logic                           expired;

    // timer is kept in 0..65535, so timer - elapsed <= 0 is timer <= elapsed
    assign expired   = (timer_reg <= elapsed);
    assign count_inc = (count_reg < kar_pkg::COUNT_MAX) ? count_reg + 1'b1 : count_reg;
    assign step_idx  = count_inc[kar_pkg::COUNT_W-1:4];

    always_comb
    begin
        case (step_idx)
            3'd0:    step_delay = cfg.delay_step[0];
            3'd1:    step_delay = cfg.delay_step[1];
            3'd2:    step_delay = cfg.delay_step[2];
            3'd3:    step_delay = cfg.delay_step[3];
            3'd4:    step_delay = cfg.delay_step[4];
            default: step_delay = cfg.delay_step[5];
        endcase
    end

    always_comb
    begin
        press      = down;
        fire       = 1'b0;
        timer_next = timer_reg;
        count_next = count_reg;
        if (down)
        begin
            timer_next = cfg.initial_delay;
            count_next = '0;
        end
        else if (enable && held)
        begin
            if (expired)
            begin
                fire       = 1'b1;
                count_next = count_inc;
                timer_next = step_delay;
            end
            else
            begin
                timer_next = timer_reg - elapsed;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timer_reg <= '0;
            count_reg <= '0;
        end
        else if (update)
        begin
            timer_reg <= timer_next;
            count_reg <= count_next;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= kar_pkg::COUNT_MAX)
        else $error("repeat count above saturation");

    a_press_clears: assert property (@(posedge clk) disable iff (!rst_n)
        update && press |=> count_reg == '0)
        else $error("fresh press did not clear count");

    a_fire_counts: assert property (@(posedge clk) disable iff (!rst_n)
        update && fire |=> count_reg != '0)
        else $error("repeat left count at zero");

    a_quiet_hold: assert property (@(posedge clk) disable iff (!rst_n)
        update && !press && !fire |=> $stable(count_reg))
        else $error("count moved without press or repeat");

endmodule

`default_nettype wire

// File: sv/key_auto_repeat_accelerating.sv
`timescale 1ns / 1ps
`default_nettype none

// path: a word taken on s_* is held in the input register; its result is registered
// in the output register and offered on m_*
// throughput: one word per cycle while m_tready does not stall the output register
// reset: timers and repeat counts clear to zero, config registers load defaults,
// both pipeline registers empty
module key_auto_repeat_accelerating
#(
    parameter int NUM_KEYS = 8
)
(
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    // down_event_mask, held_mask, elapsed_ms
    input  wire logic [31:0]                    s_tdata,
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    // press_mask, repeat_mask
    output logic [15:0]                         m_tdata,
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [kar_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [kar_pkg::CFG_DATA_W-1:0] cfg_data
);

    localparam int ACTIVE_KEYS = (NUM_KEYS < kar_pkg::MASK_W) ? NUM_KEYS : kar_pkg::MASK_W;

    kar_pkg::cfg_t               cfg;
    logic                        in_valid_reg;
    logic [kar_pkg::MASK_W-1:0]  down_reg;
    logic [kar_pkg::MASK_W-1:0]  held_reg;
    logic [kar_pkg::DELAY_W-1:0] elapsed_reg;
    logic                        out_valid_reg;
    logic [kar_pkg::MASK_W-1:0]  press_reg;
    logic [kar_pkg::MASK_W-1:0]  repeat_reg;
    logic [kar_pkg::MASK_W-1:0]  press_next;
    logic [kar_pkg::MASK_W-1:0]  repeat_next;
    logic                        advance;
    logic                        update;

    assign cfg_ready = 1'b1;

    kar_cfg u_cfg
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    assign advance  = !out_valid_reg || m_tready;
    assign update   = in_valid_reg && advance;
    assign s_tready = !in_valid_reg || advance;

    for (genvar k = 0; k < kar_pkg::MASK_W; k++)
    begin : g_key
        if (k < ACTIVE_KEYS)
        begin : g_lane
            kar_lane u_lane
            (
                .clk     (clk),
                .rst_n   (rst_n),
                .update  (update),
                .down    (down_reg[k]),
                .held    (held_reg[k]),
                .enable  (cfg.repeat_enable[k]),
                .elapsed (elapsed_reg),
                .cfg     (cfg),
                .press   (press_next[k]),
                .fire    (repeat_next[k])
            );
        end
        else
        begin : g_idle
            assign press_next[k]  = 1'b0;
            assign repeat_next[k] = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_tready)
            begin
                in_valid_reg <= s_tvalid;
            end
            if (advance)
            begin
                out_valid_reg <= in_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            down_reg    <= s_tdata[7:0];
            held_reg    <= s_tdata[15:8];
            elapsed_reg <= s_tdata[31:16];
        end
        if (update)
        begin
            press_reg  <= press_next;
            repeat_reg <= repeat_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {repeat_reg, press_reg};

endmodule

`default_nettype wire
